### hdl/rle_pkg.sv
// rle_pkg: shared constants and types for the byte run-length encoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rle_pkg;

  // longest run before it is closed and a new one opened
  localparam logic [7:0] MAX_RUN = 8'd255;

  // reset value of the output capacity register
  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  // saturation point of the pair counter
  localparam logic [15:0] PAIRS_MAX = 16'hFFFF;

  // pair command queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // what one input byte leaves for the back end: an optional closed run and
  // an optional final (flushed) run
  typedef struct packed {
    logic       has_close;
    logic [7:0] close_len;
    logic [7:0] close_val;
    logic       has_final;
    logic [7:0] final_len;
    logic [7:0] final_val;
  } rle_cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } rle_q_stat_t;

endpackage

### hdl/rle_if.sv
// rle channel interfaces: input bytes, output pairs, configuration writes
// valid/ready handshake on each; no package dependency
`timescale 1ns / 1ps

interface rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rle_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  run_length;
  logic [7:0]  run_value;
  logic        final_run;
  logic        fits;
  logic [15:0] encoded_length;

  modport source (output valid, output run_length, output run_value, output final_run,
                  output fits, output encoded_length, input ready);
  modport sink   (input valid, input run_length, input run_value, input final_run,
                  input fits, input encoded_length, output ready);
endinterface

interface rle_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/rle_front.sv
// rle_front: accepts bytes, tracks the open run, pushes closed/flushed runs
// depends on rle_pkg and rle_in_if
`timescale 1ns / 1ps

module rle_front import rle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rle_in_if.sink      in_ch,
  input  rle_q_stat_t q_stat,
  output logic        q_push,
  output rle_cmd_t    q_wdata
);

  logic       open_r, open_nxt;
  logic [7:0] val_r, val_nxt;
  logic [7:0] len_r, len_nxt;

  logic       accept;
  logic       extend;
  logic       close;
  logic [7:0] run_len;
  logic [7:0] run_val;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    extend = open_r && (in_ch.data_byte == val_r) && (len_r < MAX_RUN);
    close  = open_r && !extend;
    run_len = extend ? (len_r + 8'd1) : 8'd1;
    run_val = in_ch.data_byte;

    q_wdata.has_close = close;
    q_wdata.close_len = len_r;
    q_wdata.close_val = val_r;
    q_wdata.has_final = in_ch.last_byte;
    q_wdata.final_len = run_len;
    q_wdata.final_val = run_val;

    q_push = accept && (close || in_ch.last_byte);

    open_nxt = open_r;
    val_nxt  = val_r;
    len_nxt  = len_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        open_nxt = 1'b0;
        val_nxt  = 8'd0;
        len_nxt  = 8'd0;
      end else begin
        open_nxt = 1'b1;
        val_nxt  = run_val;
        len_nxt  = run_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      val_r  <= 8'd0;
      len_r  <= 8'd0;
    end else begin
      open_r <= open_nxt;
      val_r  <= val_nxt;
      len_r  <= len_nxt;
    end
  end

  a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (len_r != 8'd0))
    else $error("open run with zero length");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_byte) |=> !open_r)
    else $error("run still open after last byte");

endmodule

### hdl/rle_queue.sv
// rle_queue: small register queue of pair commands between front and back
// depends on rle_pkg
`timescale 1ns / 1ps

module rle_queue import rle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rle_cmd_t    wdata,
  input  logic        pop,
  output rle_cmd_t    rdata,
  output rle_q_stat_t stat
);

  rle_cmd_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    wr_ptr_nxt = do_push ? Q_PTR_W'((32'(wr_ptr_r) + 1) % Q_DEPTH) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? Q_PTR_W'((32'(rd_ptr_r) + 1) % Q_DEPTH) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.full && !pop) |=> stat.full)
    else $error("full queue lost an entry");

endmodule

### hdl/rle_back.sv
// rle_back: drains pair commands, numbers pairs, checks capacity, output register
// depends on rle_pkg, rle_out_if and rle_cfg_if
`timescale 1ns / 1ps

module rle_back import rle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rle_q_stat_t q_stat,
  input  rle_cmd_t    q_rdata,
  output logic        q_pop,
  rle_out_if.source   out_ch,
  rle_cfg_if.sink     cfg_ch
);

  logic [15:0] cap_r, cap_nxt;
  logic [15:0] pairs_r, pairs_nxt;
  logic        phase_r, phase_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  len_r, val_r;
  logic        final_r, fits_r;
  logic [15:0] enc_r;

  logic        load;
  logic        take;
  logic        emit_close;
  logic [17:0] needed;
  logic        fit;

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = valid_r;
  assign out_ch.run_length     = len_r;
  assign out_ch.run_value      = val_r;
  assign out_ch.final_run      = final_r;
  assign out_ch.fits           = fits_r;
  assign out_ch.encoded_length = enc_r;

  always_comb begin
    load       = !valid_r || out_ch.ready;
    take       = load && !q_stat.empty;
    emit_close = q_rdata.has_close && !phase_r;
    // bytes needed up to and including this pair
    needed     = {1'b0, pairs_r, 1'b0} + 18'd2;
    fit        = needed <= {2'b00, cap_r};

    q_pop     = take && (!emit_close || !q_rdata.has_final);
    phase_nxt = take ? (emit_close && q_rdata.has_final) : phase_r;

    pairs_nxt = pairs_r;
    if (take) begin
      if (!emit_close) begin
        pairs_nxt = 16'd0;
      end else if (pairs_r != PAIRS_MAX) begin
        pairs_nxt = pairs_r + 16'd1;
      end
    end

    valid_nxt = take ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);
    cap_nxt   = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.data : cap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      pairs_r <= 16'd0;
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      cap_r   <= cap_nxt;
      pairs_r <= pairs_nxt;
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      len_r   <= emit_close ? q_rdata.close_len : q_rdata.final_len;
      val_r   <= emit_close ? q_rdata.close_val : q_rdata.final_val;
      final_r <= !emit_close;
      fits_r  <= fit;
      enc_r   <= (!emit_close && fit) ? needed[15:0] : 16'd0;
    end
  end

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.run_length != 8'd0))
    else $error("pair with zero length");

  a_enc_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.encoded_length != 16'd0) |-> (out_ch.final_run && out_ch.fits))
    else $error("encoded length on a non-final or overflowed pair");

  a_phase_entry: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> !q_stat.empty)
    else $error("second half pending with empty queue");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !emit_close) |=> (pairs_r == 16'd0))
    else $error("pair counter not cleared after final pair");

endmodule

### hdl/byte_run_length_encoder_top.sv
// byte_run_length_encoder_top: byte stream in, (length, value) pairs out
// depends on rle_pkg, rle_if, rle_front, rle_queue and rle_back
//
//   channel | dir | modport     | payload
//   in_ch   | in  | rle_in_if   | data_byte[7:0], last_byte
//   out_ch  | out | rle_out_if  | run_length[7:0], run_value[7:0], final_run,
//           |     |             | fits, encoded_length[15:0]
//   cfg_ch  | in  | rle_cfg_if  | data[15:0] = output capacity in bytes
//
// one byte can be accepted every cycle while the pair queue has room; a byte
// that closes a run or ends the stream reaches out_ch through the queue and
// then the output register, which delivers one pair per cycle while out_ch
// is ready; a byte that closes a run and ends the stream makes two pairs
// a four-entry pair queue sits between the run tracker and the output side;
// in_ch stalls only when that queue is full
// rst_n is synchronous, active low; it clears run state, the queue and the
// pair counter, and sets the capacity to 65535
// cfg_ch is always ready; writes are expected only while no stream is open
`timescale 1ns / 1ps

module byte_run_length_encoder_top import rle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rle_in_if.sink    in_ch,
  rle_out_if.source out_ch,
  rle_cfg_if.sink   cfg_ch
);

  // front to back pair command path
  logic        q_push;
  logic        q_pop;
  rle_cmd_t    q_wdata;
  rle_cmd_t    q_rdata;
  rle_q_stat_t q_stat;

  // run tracking: compares each byte with the open run and decides whether a
  // run closes and whether the stream ends
  rle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  // decouples the byte side from output back-pressure
  rle_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // pair numbering, capacity check and the output register
  rle_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for byte_run_length_encoder_top
// depends on rle_pkg, the rle channel interfaces and the block's rtl
// directed streams, back-pressure and random streams, checked against an in-bench pair model
`timescale 1ns / 1ps

module tb_top;
  import rle_pkg::*;

  localparam int HOLD_CYCLES     = 300;   // long receiver hold-off for the pressure test
  localparam int PAUSE_CYCLES    = 10;    // quiet time before a capacity write and at the end
  localparam int QUIET_LIMIT     = 4000;  // cycles without any transfer before giving up
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 40;
  localparam int REPORT_CAP      = 40;    // mismatch lines printed before going quiet

  // one (length, value) pair as the encoder should emit it
  typedef struct {
    logic [7:0]  len;
    logic [7:0]  val;
    logic        fin;
    logic        fit;
    logic [15:0] enc;
  } enc_pair_t;

  logic clk;
  logic rst_n;

  rle_in_if  in_ch ();
  rle_out_if out_ch ();
  rle_cfg_if cfg_ch ();

  byte_run_length_encoder_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // encoder model state, mirrors the block's run tracker and pair counter
  logic [15:0] capacity    = CAP_RESET;
  logic        run_active  = 1'b0;
  logic [7:0]  run_byte    = '0;
  logic [7:0]  run_count   = '0;
  logic [15:0] pair_count  = '0;

  enc_pair_t   pending_pairs[$];

  // run bookkeeping
  int  failures      = 0;
  int  bytes_sent    = 0;
  int  pairs_checked = 0;
  int  caps_written  = 0;
  int  in_stalls     = 0;
  int  quiet_cycles  = 0;
  bit  idle_on       = 1'b1;  // random gaps on both sides when set
  bit  hold_request  = 1'b0;  // asks the receiver for one long hold-off

  // close the open run as the next pair of the stream
  function automatic void close_run(input logic is_final);
    enc_pair_t   p;
    int unsigned need;
    need  = 2 * (int'(pair_count) + 1);
    p.len = run_count;
    p.val = run_byte;
    p.fin = is_final;
    p.fit = (need <= int'(capacity));
    p.enc = (is_final && p.fit) ? need[15:0] : 16'd0;
    pending_pairs.push_back(p);
    if (pair_count != PAIRS_MAX) pair_count = pair_count + 16'd1;
  endfunction

  // expected pairs for one accepted byte: 0, 1 or 2
  function automatic void encode_byte(input logic [7:0] b, input logic lst);
    if (run_active && b == run_byte && run_count < MAX_RUN) begin
      run_count = run_count + 8'd1;
    end else begin
      if (run_active) close_run(1'b0);
      run_active = 1'b1;
      run_byte   = b;
      run_count  = 8'd1;
    end
    if (lst) begin
      close_run(1'b1);
      run_active = 1'b0;
      run_byte   = '0;
      run_count  = '0;
      pair_count = '0;
    end
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // runs mostly short, now and then around the maximum run length
  function automatic int pick_run_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(250, 262);
  endfunction

  // one byte transfer; valid stays high when the next byte follows with no gap
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_byte(b, lst);
    bytes_sent++;
  endtask

  // drop valid, wait for every expected pair, then let the pipeline go quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  // capacity register write, only ever issued between streams with the block idle
  task automatic write_capacity(input logic [15:0] cap);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    capacity = cap;
    caps_written++;
  endtask

  // capacity from reset, single-byte streams at both byte extremes
  task automatic test_single_byte_streams();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b1);
    settle();
  endtask

  // a final byte that differs closes one run and flushes another in one go
  task automatic test_close_and_flush();
    write_capacity(CAP_RESET);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b1);
    settle();
  endtask

  // runs that hit the maximum length: equal byte after a full run, then a
  // differing one
  task automatic test_full_runs();
    for (int i = 0; i < 256; i++) send_byte(8'h7E, i == 255);
    for (int i = 0; i < 255; i++) send_byte(8'h80, 1'b0);
    send_byte(8'h81, 1'b1);
    settle();
  endtask

  // capacity below one pair, then just one pair's worth
  task automatic test_small_capacity();
    logic [15:0] caps [4];
    caps = '{16'd0, 16'd1, 16'd2, 16'd3};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b1);
    end
  endtask

  // streams past the capacity keep emitting with fits low; exact fit at the edge
  task automatic test_overflow();
    write_capacity(16'd6);
    for (int i = 0; i < 5; i++) send_byte(8'(i * 37), i == 4);
    write_capacity(16'd8);
    for (int i = 0; i < 4; i++) send_byte(8'(8'hF0 + i), i == 3);
    settle();
  endtask

  // capacity survives the end of a stream
  task automatic test_capacity_persists();
    write_capacity(16'd10);
    for (int i = 0; i < 6; i++) send_byte(8'(i), i == 5);
    for (int i = 0; i < 6; i++) send_byte(8'(8'hC0 | i), i == 5);
    settle();
  endtask

  // receiver holds off while the sender keeps offering pair-producing bytes
  task automatic test_backpressure();
    write_capacity(CAP_RESET);
    idle_on      = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'(i[0] ? 8'h5A : 8'hA5), i == 39);
    settle();
    idle_on = 1'b1;
  endtask

  // random streams in phases, each with its own capacity setting
  task automatic test_random_streams();
    logic [7:0]  cur;
    logic [15:0] cap;
    int          n_runs;
    int          run_len;
    int          phase_items;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       cap = CAP_RESET;
        1:       cap = 16'd0;
        2:       cap = 16'd1;
        3:       cap = 16'd2;
        4:       cap = 16'd3;
        5, 6, 9: cap = 16'($urandom_range(4, 30));
        7:       cap = 16'($urandom_range(0, 65535));
        default: cap = 16'd65534;
      endcase
      write_capacity(cap);
      // every third phase runs flat out on both sides
      idle_on     = (phase % 3 != 2);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        n_runs = $urandom_range(1, 10);
        cur    = 8'($urandom);
        for (int k = 0; k < n_runs; k++) begin
          run_len = pick_run_length();
          // mostly a new value; sometimes the same one, which merges the runs
          if (k > 0 && $urandom_range(0, 7) != 0) cur = cur ^ 8'($urandom_range(1, 255));
          for (int j = 0; j < run_len; j++) begin
            send_byte(cur, (k == n_runs - 1) && (j == run_len - 1));
            phase_items++;
          end
        end
      end
    end
    idle_on = 1'b1;
    settle();
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result checker: every pair transfer is matched against the oldest expectation
  always @(posedge clk) begin
    enc_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pairs.size() == 0) begin
        failures++;
        if (failures <= REPORT_CAP)
          $display("%0t: unexpected pair, expected none, actual len %0d val %0d",
                   $time, out_ch.run_length, out_ch.run_value);
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        compare_field("run_length", 16'(want.len), 16'(out_ch.run_length));
        compare_field("run_value", 16'(want.val), 16'(out_ch.run_value));
        compare_field("final_run", 16'(want.fin), 16'(out_ch.final_run));
        compare_field("fits", 16'(want.fit), 16'(out_ch.fits));
        compare_field("encoded_length", want.enc, out_ch.encoded_length);
      end
    end
  end

  // receiver: random hold-offs, plus one long hold when a test asks for it
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on any transfer, and a tally of input stalls
  always @(posedge clk) begin
    if (in_ch.valid && !in_ch.ready && rst_n) in_stalls++;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d pairs outstanding",
                 $time, QUIET_LIMIT, pending_pairs.size());
        $display("byte_run_length_encoder_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.last_byte  = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_byte_streams();
    test_close_and_flush();
    test_full_runs();
    test_small_capacity();
    test_overflow();
    test_capacity_persists();
    test_backpressure();
    test_random_streams();

    settle();
    if (pending_pairs.size() != 0) begin
      failures++;
      $display("%0t: %0d expected pairs never arrived", $time, pending_pairs.size());
    end

    $display("run covered %0d input bytes and %0d checked pairs over %0d capacity settings",
             bytes_sent, pairs_checked, caps_written);
    $display("input held off for %0d cycles; %0d mismatches seen", in_stalls, failures);
    if (failures == 0) begin
      $display("byte_run_length_encoder_top regression: pass");
    end else begin
      $display("byte_run_length_encoder_top regression: fail");
    end
    $finish;
  end

endmodule
